// ===== hdl/xmi_pkg.sv =====
// ----------------------------------------------------------------------------
// xmi_pkg
// Shared types and constants of the XMI to MIDI event parser.
// ----------------------------------------------------------------------------
package xmi_pkg;

    localparam logic [7:0] META_PREFIX = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_SMPTE  = 8'h54;
    localparam logic [7:0] META_TSIG   = 8'h58;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_PORT   = 8'h21;

    localparam int unsigned RUN_MAX = 8;

    // Request from the parser to the emitter: one run of up to eight bytes.
    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][7:0] bytes;
        logic [7:0]      first;
        logic [7:0]      use_off;
        logic            err;
        logic [31:0]     dur;
    } t_run;

    // Translate an XMI patch number to a General MIDI program.
    function automatic logic [7:0] translate_patch(input logic [7:0] p);
        logic [7:0] r;
        r = p;
        case (p)
            8'd13: r = 8'd19;   8'd16: r = 8'd6;    8'd22: r = 8'd8;
            8'd23: r = 8'd8;    8'd24: r = 8'd62;   8'd25: r = 8'd63;
            8'd32: r = 8'd88;   8'd33: r = 8'd101;  8'd34: r = 8'd52;
            8'd36: r = 8'd97;   8'd38: r = 8'd93;   8'd43: r = 8'd102;
            8'd51: r = 8'd45;   8'd52: r = 8'd40;   8'd53: r = 8'd40;
            8'd54: r = 8'd42;   8'd55: r = 8'd42;   8'd56: r = 8'd43;
            8'd57: r = 8'd46;   8'd58: r = 8'd46;   8'd59: r = 8'd24;
            8'd70: r = 8'd35;   8'd72: r = 8'd73;   8'd74: r = 8'd72;
            8'd77: r = 8'd74;   8'd82: r = 8'd71;   8'd83: r = 8'd71;
            8'd84: r = 8'd68;   8'd85: r = 8'd69;   8'd86: r = 8'd70;
            8'd88: r = 8'd56;   8'd89: r = 8'd56;   8'd90: r = 8'd57;
            8'd92: r = 8'd60;   8'd93: r = 8'd60;   8'd94: r = 8'd58;
            8'd96: r = 8'd61;   8'd97: r = 8'd11;   8'd103: r = 8'd13;
            8'd104: r = 8'd12;  8'd105: r = 8'd107; 8'd107: r = 8'd77;
            8'd108: r = 8'd78;  8'd109: r = 8'd79;  8'd112: r = 8'd47;
            8'd117: r = 8'd116; 8'd121: r = 8'd112; 8'd122: r = 8'd55;
            8'd127: r = 8'd121;
            default: r = p;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/xmi_parse.sv =====
// ----------------------------------------------------------------------------
// xmi_parse
// Front end: parses one XMI byte per valid cycle, tracks time, builds runs.
// ----------------------------------------------------------------------------
module xmi_parse import xmi_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    output logic                  o_run_valid,
    output t_run                  o_run,
    output logic [TIME_WIDTH-1:0] o_run_time
);

    typedef enum logic [2:0] {
        PH_EVENT, PH_CHDATA, PH_NOTELEN, PH_METACMD, PH_METADATA, PH_METALEN, PH_SKIP
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_time, n_time;
    logic [7:0]            r_status, n_status;
    logic [7:0]            r_held [6];
    logic [7:0]            r_count, n_count;
    logic [31:0]           r_acc, n_acc;
    logic                  r_halt, n_halt;
    logic                  n_valid;
    t_run                  n_run;
    logic [7:0]            b, st;
    logic [3:0]            need;
    logic [31:0]           acc_or;

    // Decode the current byte.
    always_comb begin
        n_phase = r_phase; n_time = r_time; n_status = r_status;
        n_count = r_count; n_acc = r_acc; n_halt = r_halt;
        n_valid = 1'b0; n_run = '0;
        b = i_byte; st = r_status; need = 4'd2;
        acc_or = r_acc | {25'd0, i_byte[6:0]};
        if (i_valid && !r_halt) begin
            case (r_phase)
                PH_EVENT: begin
                    if (!b[7]) begin
                        n_time = r_time + TIME_WIDTH'({b, 1'b0}) + TIME_WIDTH'(b);
                    end else begin
                        if (b[7:4] != 4'hF && b[3:0] == 4'd8) b = b + 8'd1;
                        if (b[7:4] == 4'hA) begin
                            n_valid = 1'b1; n_run.len = 4'd1; n_run.bytes[0] = b;
                            n_run.err = 1'b1; n_halt = 1'b1;
                        end else if (b[7:4] == 4'hF) begin
                            if (b == META_PREFIX) n_phase = PH_METACMD;
                        end else begin
                            n_status = b; n_count = 8'd0; n_phase = PH_CHDATA;
                        end
                    end
                end
                PH_CHDATA: begin
                    need = (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 4'd1 : 4'd2;
                    n_count = r_count + 8'd1;
                    if (n_count >= {4'd0, need}) begin
                        n_phase = PH_EVENT;
                        case (st[7:4])
                            4'h9: begin
                                n_acc = '0; n_phase = PH_NOTELEN;
                            end
                            4'hB, 4'hE: begin
                                n_valid = 1'b1; n_run.len = 4'd3;
                                n_run.bytes[0] = st; n_run.bytes[1] = r_held[0];
                                n_run.bytes[2] = b; n_run.first[0] = 1'b1;
                            end
                            4'hC: begin
                                n_valid = 1'b1; n_run.len = 4'd2;
                                n_run.bytes[0] = st; n_run.bytes[1] = translate_patch(b);
                                n_run.first[0] = 1'b1;
                            end
                            4'hD: begin
                                n_valid = 1'b1; n_run.len = 4'd2;
                                n_run.bytes[0] = st; n_run.bytes[1] = b;
                                n_run.first[0] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                PH_NOTELEN: begin
                    if (b[7]) begin
                        n_acc = {acc_or[24:0], 7'd0};
                    end else begin
                        n_acc = acc_or;
                        n_valid = 1'b1; n_run.len = 4'd6; n_run.dur = acc_or;
                        n_run.bytes[0] = st; n_run.bytes[1] = r_held[0];
                        n_run.bytes[2] = r_held[1]; n_run.bytes[3] = st - 8'h10;
                        n_run.bytes[4] = r_held[0]; n_run.bytes[5] = r_held[1];
                        n_run.first = 8'b0000_1001; n_run.use_off = 8'b0011_1000;
                        n_phase = PH_EVENT;
                    end
                end
                PH_METACMD: begin
                    n_status = b; n_count = 8'd0;
                    if (b == META_TEMPO) begin
                        n_count = 8'd4; n_phase = PH_SKIP;
                    end else if (b == META_SMPTE || b == META_TSIG || b == META_PORT) begin
                        n_phase = PH_METADATA;
                    end else if (b == META_EOT) begin
                        n_valid = 1'b1; n_run.len = 4'd3;
                        n_run.bytes[0] = META_PREFIX; n_run.bytes[1] = META_EOT;
                        n_run.first[0] = 1'b1; n_phase = PH_EVENT;
                    end else begin
                        n_phase = PH_METALEN;
                    end
                end
                PH_METADATA: begin
                    need = (st == META_SMPTE) ? 4'd6 : ((st == META_TSIG) ? 4'd5 : 4'd2);
                    n_count = r_count + 8'd1;
                    if (n_count >= {4'd0, need}) begin
                        n_valid = 1'b1; n_run.len = need + 4'd2;
                        n_run.bytes[0] = META_PREFIX; n_run.bytes[1] = st;
                        for (int k = 0; k < 6; k++) begin
                            if (k < int'(r_count)) n_run.bytes[k+2] = r_held[k];
                        end
                        n_run.bytes[r_count[2:0] + 3'd2] = b;
                        n_run.first[0] = 1'b1; n_phase = PH_EVENT;
                    end
                end
                PH_METALEN: begin
                    n_count = b;
                    n_phase = (b != 8'd0) ? PH_SKIP : PH_EVENT;
                end
                PH_SKIP: begin
                    if (r_count != 8'd0) n_count = r_count - 8'd1;
                    if (n_count == 8'd0) n_phase = PH_EVENT;
                end
                default: n_phase = PH_EVENT;
            endcase
        end
    end

    // Hold state and register the run request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EVENT; r_time <= '0; r_status <= '0; r_count <= '0;
            r_acc <= '0; r_halt <= 1'b0; o_run_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_time <= n_time; r_status <= n_status;
            r_count <= n_count; r_acc <= n_acc; r_halt <= n_halt;
            o_run_valid <= n_valid;
        end
    end

    // Store data bytes and register the run and its time; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_valid && !r_halt && (r_phase == PH_CHDATA || r_phase == PH_METADATA)
            && r_count < 8'd6) begin
            r_held[r_count[2:0]] <= i_byte;
        end
        o_run      <= n_run;
        o_run_time <= r_time;
    end

endmodule

// ===== hdl/xmi_emit.sv =====
// ----------------------------------------------------------------------------
// xmi_emit
// Back end: run queue, note-off time adder, byte serializer and output register.
// ----------------------------------------------------------------------------
module xmi_emit import xmi_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_run_valid,
    input  t_run                  i_run,
    input  logic [TIME_WIDTH-1:0] i_run_time,
    output logic [1:0]            o_room,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [31:0]           o_event_time,
    output logic [7:0]            o_out_byte,
    output logic                  o_event_first,
    output logic                  o_run_last,
    output logic                  o_parse_error
);

    localparam int QD = 4;

    // Run queue: four entries, note-off time computed on entry.
    t_run                  r_q   [QD];
    logic [TIME_WIDTH-1:0] r_qt  [QD];
    logic [TIME_WIDTH-1:0] r_qo  [QD];
    logic [1:0]            r_wp, r_rp;
    logic [2:0]            r_cnt;
    logic [2:0]            r_idx;
    logic                  r_ov;
    logic [31:0]           r_ot;
    logic [7:0]            r_ob;
    logic                  r_of, r_ol, r_oe;
    logic                  take, load, pull;
    t_run                  cur;
    logic [TIME_WIDTH+1:0] off3;

    assign off3  = {2'b0, i_run_time} + TIME_WIDTH'({i_run.dur, 1'b0}) + TIME_WIDTH'(i_run.dur);
    assign cur   = r_q[r_rp];
    assign load  = !r_ov || i_pop;
    assign take  = (r_cnt != 3'd0) && load;
    assign pull  = take && ({1'b0, r_idx} + 4'd1 >= cur.len);
    assign o_room = (r_cnt >= 3'd3) ? 2'd0 : 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_idx <= '0; r_ov <= 1'b0;
        end else begin
            if (i_run_valid) r_wp <= r_wp + 2'd1;
            if (pull) begin
                r_rp <= r_rp + 2'd1; r_idx <= '0;
            end else if (take) begin
                r_idx <= r_idx + 3'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_run_valid} - {2'd0, pull};
            if (load) r_ov <= (r_cnt != 3'd0);
        end
    end

    // Store entries and the output register.
    always_ff @(posedge i_clk) begin
        if (i_run_valid) begin
            r_q[r_wp]  <= i_run;
            r_qt[r_wp] <= i_run_time;
            r_qo[r_wp] <= off3[TIME_WIDTH-1:0];
        end
        if (take) begin
            r_ot <= 32'(cur.use_off[r_idx] ? r_qo[r_rp] : r_qt[r_rp]);
            r_ob <= cur.bytes[r_idx];
            r_of <= cur.first[r_idx];
            r_ol <= ({1'b0, r_idx} + 4'd1 >= cur.len);
            r_oe <= cur.err;
        end
    end

    assign o_empty       = !r_ov;
    assign o_event_time  = r_ot;
    assign o_out_byte    = r_ob;
    assign o_event_first = r_of;
    assign o_run_last    = r_ol;
    assign o_parse_error = r_oe;

endmodule

// ===== hdl/xmi_to_midi_event_parser_core.sv =====
// ----------------------------------------------------------------------------
// xmi_to_midi_event_parser_core
// Converts an XMI event byte stream into timestamped MIDI event bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_in_byte and raise i_push while o_full is low; one
//   XMI byte is taken per edge. Output queue: while o_empty is low the oldest
//   MIDI byte sits on o_out_byte with its time and flags; i_pop takes it.
//   A result byte passes the parser's run register, the run queue and the
//   output register. The parser takes one byte per cycle while o_full is
//   low; the serializer emits one result byte per cycle while the receiver
//   pops, and a note-on becomes a run of six bytes.
//   A four-entry run queue between parser and serializer decouples them;
//   o_full rises when it nears full, or while the receiver stalls long enough.
//   Reset (synchronous, active low) clears parser state, time and queues.
//   After status 0xA0 one error byte is emitted and later input is dropped.
// ----------------------------------------------------------------------------
module xmi_to_midi_event_parser_core import xmi_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_in_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_event_time,
    output logic [7:0]  o_out_byte,
    output logic        o_event_first,
    output logic        o_run_last,
    output logic        o_parse_error
);

    logic                  run_valid;
    t_run                  run;
    logic [TIME_WIDTH-1:0] run_time;
    logic [1:0]            room;

    assign o_full = (room == 2'd0);

    xmi_parse #(.TIME_WIDTH(TIME_WIDTH)) u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_push && !o_full),
        .i_byte(i_in_byte), .o_run_valid(run_valid), .o_run(run), .o_run_time(run_time)
    );

    xmi_emit #(.TIME_WIDTH(TIME_WIDTH)) u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_run_valid(run_valid), .i_run(run),
        .i_run_time(run_time), .o_room(room), .o_empty(o_empty), .i_pop(i_pop),
        .o_event_time(o_event_time), .o_out_byte(o_out_byte),
        .o_event_first(o_event_first), .o_run_last(o_run_last),
        .o_parse_error(o_parse_error)
    );

endmodule

// ===== hdl/xmi_checker.sv =====
// ----------------------------------------------------------------------------
// xmi_checker
// Port-level checks of the parser core's output queue.
// ----------------------------------------------------------------------------
module xmi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [7:0]  o_out_byte,
    input logic        o_event_first,
    input logic        o_run_last,
    input logic        o_parse_error
);

    // Hold the byte while it waits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> $stable(o_out_byte))
        else $error("result changed while stalled");

    // An error byte ends its run.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_parse_error) |-> (o_run_last && !o_event_first))
        else $error("error byte not alone");

    // Event starts carry a status byte.
    a_first_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_event_first) |-> o_out_byte[7])
        else $error("event start without status");

    // Empty after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("queue not empty after reset");

endmodule

bind xmi_to_midi_event_parser_core xmi_checker u_chk (.*);
